[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the route lookup block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mrfl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Route lookup package
// Widths, operation codes and the structs passed between the block's parts.
// ---------------------------------------------------------------------------
package mrfl_pkg;

  localparam int ROW_W  = 4;
  localparam int ADDR_W = 32;
  localparam int CFG_W  = 5;
  // Largest row count the configuration register can hold.
  localparam int CFG_MAX = 2 ** CFG_W - 1;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  // Fixed part of one queued word; the match vector travels beside it.
  typedef struct packed {
    logic              write_op;
    logic [ROW_W-1:0]  row_index;
    logic [ADDR_W-1:0] hop;
  } q_ctl_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/mrfl_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Route lookup channels
// Valid/ready channels for request words, result words and configuration.
// ---------------------------------------------------------------------------

// Request words: table writes and lookups.
interface mrfl_in_if import mrfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ROW_W-1:0]  row_index;
  logic [ADDR_W-1:0] row_network;
  logic [ADDR_W-1:0] row_mask;
  logic [ADDR_W-1:0] row_gateway;
  logic [ADDR_W-1:0] lookup_address;

  modport source (output valid, operation, row_index, row_network, row_mask,
                  row_gateway, lookup_address, input ready);
  modport sink (input valid, operation, row_index, row_network, row_mask,
                row_gateway, lookup_address, output ready);
endinterface

// Result words, one for each request word.
interface mrfl_out_if import mrfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] gateway;
  logic [ROW_W-1:0]  matched_row;

  modport source (output valid, found, gateway, matched_row, input ready);
  modport sink (input valid, found, gateway, matched_row, output ready);
endinterface

// Configuration writes of the row count.
interface mrfl_cfg_if import mrfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/mrfl_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Route lookup front end
// Holds the row count and the network/mask rows, accepts request words and
// compares every row in use against the lookup address in parallel.
// ---------------------------------------------------------------------------
module mrfl_front import mrfl_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  mrfl_in_if.sink            lookup,
  mrfl_cfg_if.sink           cfg,
  input  wire q_stat_t       q_stat,
  output logic               q_push,
  output q_ctl_t             q_ctl,
  output logic [ENTRIES-1:0] q_match
);

  logic [CFG_W-1:0]   entries_in_use;
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] in_use;
  logic               accept;
  logic               is_write;

  // Configuration is always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg.valid) begin
      entries_in_use <= cfg.data;
    end
  end

  // A word is taken whenever the queue has room.
  assign lookup.ready = !q_stat.full;
  assign accept       = lookup.valid && lookup.ready;
  assign is_write     = (lookup.operation == OP_WRITE);

  // One compare cell per row. Rows beyond the writable range always report a hit.
  for (genvar r = 0; r < ENTRIES; r++) begin : g_row
    if (r < 2 ** ROW_W) begin : g_cell
      logic [ADDR_W-1:0] net;
      logic [ADDR_W-1:0] msk;

      always_ff @(posedge clk) begin
        if (accept && is_write && (lookup.row_index == ROW_W'(r))) begin
          net <= lookup.row_network;
          msk <= lookup.row_mask;
        end
      end

      assign hit[r] = ((lookup.lookup_address & msk) == net);
    end else begin : g_blank
      assign hit[r] = 1'b1;
    end

    // A row takes part only below the configured count.
    if (r < CFG_MAX) begin : g_use
      assign in_use[r] = (entries_in_use > CFG_W'(r));
    end else begin : g_unused
      assign in_use[r] = 1'b0;
    end
  end

  // Queue word: writes carry no matches, so they come out as not found.
  assign q_push        = accept;
  assign q_ctl.write_op  = is_write;
  assign q_ctl.row_index = lookup.row_index;
  assign q_ctl.hop       = lookup.row_gateway;
  assign q_match       = is_write ? '0 : (hit & in_use);

endmodule

`default_nettype wire

[hw/rtl/mrfl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Route lookup queue
// Two-entry FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
module mrfl_queue import mrfl_pkg::*; #(
  parameter int WIDTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output q_stat_t               stat
);

  logic [WIDTH-1:0] slots [2];
  logic             head;
  logic             tail;
  logic [1:0]       count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  assign pop_data       = slots[head];
  assign stat.full      = count[1];
  assign stat.not_empty = (count != 2'd0);

endmodule

`default_nettype wire

[hw/rtl/mrfl_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Route lookup back end
// Picks the lowest matching row, reads its next hop from the hop memory and
// holds the result word until it is taken. Also loads the hop memory.
// ---------------------------------------------------------------------------
module mrfl_back import mrfl_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire q_stat_t            q_stat,
  input  wire q_ctl_t             q_ctl,
  input  wire logic [ENTRIES-1:0] q_match,
  output logic                    q_pop,
  mrfl_out_if.source              result
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ADDR_W-1:0] hop_mem [ENTRIES];
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  wr_addr;
  logic [ROW_W-1:0]  idx_row;
  logic              any_hit;
  logic              wr_ok;
  logic              out_valid;
  logic              found_q;
  logic [ROW_W-1:0]  row_q;
  logic [ADDR_W-1:0] hop_rd;

  // Lowest set bit of the match vector wins.
  always_comb begin
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (q_match[i]) begin
        idx = IDX_W'(i);
      end
    end
  end
  assign any_hit = |q_match;

  // Fit row numbers between the 4-bit field and the memory address.
  if (IDX_W >= ROW_W) begin : g_wide
    assign wr_addr = IDX_W'(q_ctl.row_index);
    assign idx_row = idx[ROW_W-1:0];
  end else begin : g_narrow
    assign wr_addr = q_ctl.row_index[IDX_W-1:0];
    assign idx_row = ROW_W'(idx);
  end
  assign wr_ok = (32'(q_ctl.row_index) < 32'(ENTRIES));

  // Take the next word when the output register is free or being emptied.
  assign q_pop = q_stat.not_empty && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hop memory write and registered read, plus the result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      found_q <= any_hit;
      row_q   <= idx_row;
      hop_rd  <= hop_mem[idx];
      if (q_ctl.write_op && wr_ok) begin
        hop_mem[wr_addr] <= q_ctl.hop;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.found       = found_q;
  assign result.gateway     = found_q ? hop_rd : '0;
  assign result.matched_row = found_q ? row_q : '0;

endmodule

`default_nettype wire

[hw/rtl/masked_route_first_match_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Masked route table, first-match lookup
// Route table of network/mask/next-hop rows searched in table order.
//
//   channel   dir   carries
//   lookup    in    row write or lookup address, one word per request
//   result    out   found flag, next hop and matched row, one per request
//   cfg       in    number of rows searched
//
// One request word per cycle is accepted while the queue has room; its
// result word is registered in the queue and then in the output register.
// The parallel row compares and one hop memory read per cycle set the rate.
// Reset clears the row count, queue and output register; rows keep contents.
// A stalled result holds the back end; the two-entry queue then fills and
// the front end stops accepting.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module masked_route_first_match_lookup import mrfl_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  mrfl_in_if.sink   lookup,
  mrfl_cfg_if.sink  cfg,
  mrfl_out_if.source result
);

  localparam int Q_W = $bits(q_ctl_t) + ENTRIES;

  q_stat_t            q_stat;
  logic               q_push;
  logic               q_pop;
  q_ctl_t             push_ctl;
  logic [ENTRIES-1:0] push_match;
  q_ctl_t             pop_ctl;
  logic [ENTRIES-1:0] pop_match;
  logic [Q_W-1:0]     pop_data;

  // Front end: configuration, row cells and compares.
  mrfl_front #(.ENTRIES(ENTRIES)) u_front (
    .clk     (clk),
    .rst     (rst),
    .lookup  (lookup),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_ctl   (push_ctl),
    .q_match (push_match)
  );

  // Queue between the two halves.
  mrfl_queue #(.WIDTH(Q_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_ctl, push_match}),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  assign pop_ctl   = pop_data[Q_W-1:ENTRIES];
  assign pop_match = pop_data[ENTRIES-1:0];

  // Back end: priority pick, hop memory and result register.
  mrfl_back #(.ENTRIES(ENTRIES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .q_ctl   (pop_ctl),
    .q_match (pop_match),
    .q_pop   (q_pop),
    .result  (result)
  );

  // A miss or a write never reports a row or a hop.
  `ASSERT_SAME(a_miss_is_zero, clk, rst, result.valid && !result.found, (result.gateway == '0) && (result.matched_row == '0), "miss carries a next hop or row")
  // The front end never pushes into a full queue.
  `ASSERT_SAME(a_no_overflow, clk, rst, q_push, !q_stat.full, "push into full queue")
  // A word taken from the queue shows up as a result in the next cycle.
  `ASSERT_NEXT(a_pop_gives_result, clk, rst, q_pop, result.valid, "popped word lost")

endmodule

`default_nettype wire
